[src/mcsa_pkg.sv]
// shared constants, types and command/status bundles for the chi-square accumulator
package mcsa_pkg;

  localparam int unsigned MAX_SIDE   = 1024;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned DEN_W      = DATA_W + 1;
  localparam int unsigned RES_W      = DATA_W + 2;
  localparam int unsigned NUM_W      = 80;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_STEPS  = DIV_W / 2;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 2 * DATA_W;
  localparam int unsigned OUT_BITS   = SUM_W + CNT_W + STATUS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam longint unsigned SIDE_SQ       = longint'(MAX_SIDE) * longint'(MAX_SIDE);
  localparam longint unsigned CNT_FIELD_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam logic [CNT_W-1:0] CNT_LIMIT =
      CNT_W'(SIDE_SQ > CNT_FIELD_MAX ? CNT_FIELD_MAX : SIDE_SQ);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [DATA_W-1:0] GAIN_RESET = 32'h0001_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LEVEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_GAIN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 8'd3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_ZERO_DEN = 2'd2,
    STATUS_SAT      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MUL_SQUARE  = 2'd0,
    MUL_GAIN_LO = 2'd1,
    MUL_GAIN_HI = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     eval;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     shift;
    logic     term_check;
    logic     acc;
    logic     mean_start;
    logic     emit;
  } mcsa_cmd_t;

  typedef struct packed {
    logic do_term;
    logic last;
    logic term_ovf;
    logic div_done;
    logic count_zero;
    logic out_busy;
  } mcsa_stat_t;

endpackage

[src/mcsa_div.sv]
// shared radix-4 restoring divider, two quotient bits per cycle
module mcsa_div
  import mcsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] rem_init_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  divisor_q;
  logic [DIV_W-1:0]  work_q, work_d;

  logic [DEN_W:0] r1, r1s, r2, r2s;
  logic           ge1, ge2;

  always_comb begin
    r1     = {rem_q, work_q[DIV_W-1]};
    ge1    = r1 >= {1'b0, divisor_q};
    r1s    = ge1 ? r1 - {1'b0, divisor_q} : r1;
    r2     = {r1s[DEN_W-1:0], work_q[DIV_W-2]};
    ge2    = r2 >= {1'b0, divisor_q};
    r2s    = ge2 ? r2 - {1'b0, divisor_q} : r2;
    rem_d  = r2s[DEN_W-1:0];
    work_d = {work_q[DIV_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= rem_init_i;
      work_q    <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      work_q <= work_d;
    end
  end

  assign done_o     = busy_q && (step_q == LAST_STEP);
  assign quotient_o = work_q;

endmodule

[src/mcsa_datapath.sv]
// datapath: config registers, residual, shared multiplier, accumulator and output register
module mcsa_datapath
  import mcsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcsa_cmd_t             cmd_i,
  output mcsa_stat_t            stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0]     cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_sel_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  // configuration
  logic [DATA_W-1:0] offset_q, noise_q, gain_q;
  logic              mask_en_q;

  // pixel and working registers
  logic [DATA_W-1:0] data_q, model_q;
  logic              sel_q, last_q;
  logic [DATA_W-1:0] mag_q;
  logic [DEN_W-1:0]  den_abs_q;
  logic              den_neg_q;
  logic [SUM_W-1:0]  sq_q, plo_q, phi_q;
  logic [NUM_W-1:0]  num_q;
  logic              term_sat_q;

  // frame state
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              zero_q, zero_d;
  logic              sat_q, sat_d;

  // output register
  logic                  out_valid_q;
  logic [SUM_W-1:0]      chi_q;
  logic [CNT_W-1:0]      out_cnt_q;
  status_e               status_q;

  // residual and denominator
  logic [RES_W-1:0]  res, res_abs;
  logic              clip;
  logic [DATA_W-1:0] mag_n;
  logic [DEN_W-1:0]  den, den_abs;
  logic              counted, at_limit, den_zero;

  always_comb begin
    res = {{2{data_q[DATA_W-1]}}, data_q} - {{2{model_q[DATA_W-1]}}, model_q}
        - {{2{offset_q[DATA_W-1]}}, offset_q};
    res_abs  = res[RES_W-1] ? -res : res;
    clip     = |res_abs[RES_W-1:DATA_W];
    mag_n    = clip ? '1 : res_abs[DATA_W-1:0];
    den      = {data_q[DATA_W-1], data_q} + {noise_q[DATA_W-1], noise_q};
    den_abs  = den[DEN_W-1] ? -den : den;
    den_zero = den == '0;
    counted  = !mask_en_q || sel_q;
    at_limit = count_q >= CNT_LIMIT;
  end

  // shared 32x32 multiplier
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [SUM_W-1:0]  prod;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQUARE: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
      MUL_GAIN_LO: begin
        mul_a = gain_q;
        mul_b = sq_q[DATA_W-1:0];
      end
      MUL_GAIN_HI: begin
        mul_a = gain_q;
        mul_b = sq_q[SUM_W-1:DATA_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // product alignment: gain * square, scaled down by 2^16
  logic [95:0] wide_prod;
  assign wide_prod = {32'd0, plo_q} + {phi_q, 32'd0};

  // quotient would exceed the signed range when the top of the dividend reaches the divisor
  logic term_ovf;
  assign term_ovf = {16'd0, num_q[NUM_W-1:DIV_W-1]} >= den_abs_q;

  // shared divider
  logic             div_start, div_done;
  logic [DEN_W-1:0] div_rem_init, div_divisor;
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [SUM_W-1:0] sum_abs;

  assign sum_abs   = sum_q[SUM_W-1] ? -sum_q : sum_q;
  assign div_start = (cmd_i.term_check && !term_ovf) || cmd_i.mean_start;

  always_comb begin
    if (cmd_i.mean_start) begin
      div_rem_init = '0;
      div_dividend = sum_abs;
      div_divisor  = {{(DEN_W-CNT_W){1'b0}}, count_q};
    end else begin
      div_rem_init = {{(DEN_W-(NUM_W-DIV_W)){1'b0}}, num_q[NUM_W-1:DIV_W]};
      div_dividend = num_q[DIV_W-1:0];
      div_divisor  = den_abs_q;
    end
  end

  mcsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // signed term and saturating accumulate
  logic [SUM_W-1:0] term_mag, term;
  logic [SUM_W:0]   acc_sum;

  always_comb begin
    term_mag = term_sat_q ? SUM_MAX : div_quot;
    term     = den_neg_q ? -term_mag : term_mag;
    acc_sum  = {sum_q[SUM_W-1], sum_q} + {term[SUM_W-1], term};
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    zero_d  = zero_q;
    sat_d   = sat_q;
    if (cmd_i.eval && counted) begin
      if (at_limit) begin
        sat_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        if (clip) begin
          sat_d = 1'b1;
        end
        if (den_zero) begin
          zero_d = 1'b1;
        end
      end
    end
    if (cmd_i.term_check && term_ovf) begin
      sat_d = 1'b1;
    end
    if (cmd_i.acc) begin
      if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
        sum_d = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        sat_d = 1'b1;
      end else begin
        sum_d = acc_sum[SUM_W-1:0];
      end
    end
    if (cmd_i.emit) begin
      sum_d   = '0;
      count_d = '0;
      zero_d  = 1'b0;
      sat_d   = 1'b0;
    end
  end

  // result fields
  logic [SUM_W-1:0] chi_n;
  status_e          status_n;

  always_comb begin
    if (count_q == '0) begin
      chi_n    = '0;
      status_n = STATUS_EMPTY;
    end else begin
      chi_n = sum_q[SUM_W-1] ? -div_quot : div_quot;
      if (sat_q) begin
        status_n = STATUS_SAT;
      end else if (zero_q) begin
        status_n = STATUS_ZERO_DEN;
      end else begin
        status_n = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      noise_q     <= '0;
      gain_q      <= GAIN_RESET;
      mask_en_q   <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      zero_q      <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_OFFSET_LEVEL: offset_q  <= cfg_data_i;
          REG_NOISE_FLOOR:  noise_q   <= cfg_data_i;
          REG_NORM_GAIN:    gain_q    <= cfg_data_i;
          REG_MASK_ENABLE:  mask_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      sum_q   <= sum_d;
      count_q <= count_d;
      zero_q  <= zero_d;
      sat_q   <= sat_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      data_q  <= in_data_i[DATA_W-1:0];
      model_q <= in_data_i[IN_DATA_W-1:DATA_W];
      sel_q   <= in_sel_i;
      last_q  <= in_last_i;
    end
    if (cmd_i.eval) begin
      mag_q     <= mag_n;
      den_abs_q <= den_abs;
      den_neg_q <= den[DEN_W-1];
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_SQUARE:  sq_q  <= prod;
        MUL_GAIN_LO: plo_q <= prod;
        MUL_GAIN_HI: phi_q <= prod;
        default: ;
      endcase
    end
    if (cmd_i.shift) begin
      num_q <= wide_prod[NUM_W+15:16];
    end
    if (cmd_i.term_check) begin
      term_sat_q <= term_ovf;
    end
    if (cmd_i.emit) begin
      chi_q     <= chi_n;
      out_cnt_q <= count_q;
      status_q  <= status_n;
    end
  end

  assign stat_o.do_term    = counted && !at_limit && !den_zero;
  assign stat_o.last       = last_q;
  assign stat_o.term_ovf   = term_ovf;
  assign stat_o.div_done   = div_done;
  assign stat_o.count_zero = count_q == '0;
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, status_q, out_cnt_q, chi_q};

endmodule

[src/mcsa_ctrl.sv]
// controller state machine sequencing one pixel and the end-of-frame mean through the datapath
module mcsa_ctrl
  import mcsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output mcsa_cmd_t  cmd_o,
  input  mcsa_stat_t stat_i
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_EVAL   = 12'b0000_0000_0010,
    ST_SQUARE = 12'b0000_0000_0100,
    ST_MUL_LO = 12'b0000_0000_1000,
    ST_MUL_HI = 12'b0000_0001_0000,
    ST_SHIFT  = 12'b0000_0010_0000,
    ST_CHECK  = 12'b0000_0100_0000,
    ST_TDIV   = 12'b0000_1000_0000,
    ST_ACC    = 12'b0001_0000_0000,
    ST_FINAL  = 12'b0010_0000_0000,
    ST_MDIV   = 12'b0100_0000_0000,
    ST_EMIT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.do_term ? ST_SQUARE : ST_FINAL;
      end
      ST_SQUARE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQUARE;
        state_d       = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN_LO;
        state_d       = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN_HI;
        state_d       = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.term_check = 1'b1;
        state_d          = stat_i.term_ovf ? ST_ACC : ST_TDIV;
      end
      ST_TDIV: begin
        if (stat_i.div_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_FINAL;
      end
      ST_FINAL: begin
        if (!stat_i.last) begin
          state_d = ST_IDLE;
        end else if (stat_i.count_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.mean_start = 1'b1;
          state_d          = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (stat_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/masked_chi_square_accumulator_top.sv]
// top level of the masked chi-square accumulator
//
// input stream (s_axis): one pixel per item, data and model values in tdata,
// mask bit in tuser, end of frame in tlast. output stream (m_axis): one item
// per frame, carrying the mean chi-square term, the counted pixels and a status.
// configuration: cfg_valid_i/cfg_ready_o with a register index and 32-bit data,
// always ready; write only while no pixel is in flight.
// sequence: a pixel that feeds the sum passes through ready, eval, three
// multiplies, shift, check, the radix-4 divider over a 64-bit quotient (skipped
// when the term overflows), accumulate and final before the next is accepted.
// a pixel that is masked, beyond the count limit or has a zero denominator
// passes through ready, eval and final only. a last pixel adds the mean division
// (skipped when nothing was counted) and the step that registers the result.
// the result waits in an output register; the next frame's pixels are taken
// while it waits, and a further result holds until the receiver takes it.
// reset clears the sum, the count and the flags and restores register defaults
// (norm_gain at one in q16.16); no clearing pass is needed.
module masked_chi_square_accumulator_top
  import mcsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0]     cfg_data_i,
  // pixel stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // data_value[31:0], model_value[63:32]
  input  logic                  s_axis_tuser,  // pixel_selected
  input  logic                  s_axis_tlast,  // last_pixel
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // chi_mean[63:0], counted_pixels[84:64],
                                               // status[86:85], zero pad[87]
);

  mcsa_cmd_t  cmd;
  mcsa_stat_t stat;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  // sequencing of one pixel and the end-of-frame mean
  mcsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // arithmetic, frame state and output register
  mcsa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_sel_i    (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[verif/tb.sv]
// self-checking testbench for the masked chi-square accumulator
module tb;
  import mcsa_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 5000;  // slowest frame plus the long hold-off, several times
  localparam int unsigned SETTLE_CYCLES = 100;   // pixel pass plus mean division, with margin
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned N_PHASES      = 9;
  localparam int unsigned PHASE_ITEMS   = 200;

  typedef struct {
    logic [SUM_W-1:0] mean;
    logic [CNT_W-1:0] count;
    status_e          status;
  } chi_result_t;

  // running chi-square sum per frame, with the expected frame means in order
  class chi_mean_board;
    logic [DATA_W-1:0]        offset_reg;
    logic [DATA_W-1:0]        noise_reg;
    logic [DATA_W-1:0]        gain_reg;
    logic                     mask_on;
    logic signed [SUM_W-1:0]  sum_q;
    logic [CNT_W-1:0]         count_q;
    bit                       zero_den_flag;
    bit                       sat_flag;
    chi_result_t              expected_means[$];
    int unsigned              errors;

    function new();
      offset_reg = '0;
      noise_reg  = '0;
      gain_reg   = GAIN_RESET;
      mask_on    = 1'b0;
      clear_frame();
      errors     = 0;
    endfunction

    function void clear_frame();
      sum_q         = '0;
      count_q       = '0;
      zero_den_flag = 1'b0;
      sat_flag      = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_OFFSET_LEVEL: offset_reg = val;
        REG_NOISE_FLOOR:  noise_reg  = val;
        REG_NORM_GAIN:    gain_reg   = val;
        REG_MASK_ENABLE:  mask_on    = val[0];
        default: ;
      endcase
    endfunction

    // one counted pixel: gain * |residual|^2 / (|den| << 16), signed by the denominator
    function void add_term(logic [DATA_W-1:0] data_q, logic [DATA_W-1:0] model_q);
      logic signed [63:0]      data_x, resid, den;
      logic [63:0]             mag, sq, den_mag;
      logic [127:0]            quo;
      logic signed [SUM_W-1:0] term;
      logic signed [SUM_W:0]   acc;
      data_x = {{32{data_q[31]}}, data_q};
      resid  = data_x - {{32{model_q[31]}}, model_q} - {{32{offset_reg[31]}}, offset_reg};
      den    = data_x + {{32{noise_reg[31]}}, noise_reg};
      if (count_q >= CNT_LIMIT) begin
        sat_flag = 1'b1;
        return;
      end
      count_q++;
      mag = resid[63] ? -resid : resid;
      if (mag > 64'hFFFF_FFFF) begin
        mag      = 64'hFFFF_FFFF;
        sat_flag = 1'b1;
      end
      if (den == 0) begin
        zero_den_flag = 1'b1;
        return;
      end
      den_mag = den[63] ? -den : den;
      sq      = mag * mag;
      quo     = (128'(gain_reg) * 128'(sq)) / 128'(den_mag << 16);
      if (quo > 128'(SUM_MAX)) begin
        quo      = 128'(SUM_MAX);
        sat_flag = 1'b1;
      end
      term = den[63] ? -quo[63:0] : quo[63:0];
      acc  = {sum_q[63], sum_q} + {term[63], term};
      if (acc[64] != acc[63]) begin
        sum_q    = acc[64] ? SUM_MIN : SUM_MAX;
        sat_flag = 1'b1;
      end else begin
        sum_q = acc[63:0];
      end
    endfunction

    function void take_pixel(logic [DATA_W-1:0] data_q, logic [DATA_W-1:0] model_q,
                             logic sel, logic last);
      chi_result_t want;
      logic [63:0] smag, q;
      if (!mask_on || sel) add_term(data_q, model_q);
      if (!last) return;
      if (count_q == 0) begin
        want.mean   = '0;
        want.status = STATUS_EMPTY;
      end else begin
        smag        = sum_q[63] ? -sum_q : sum_q;
        q           = smag / 64'(count_q);
        want.mean   = sum_q[63] ? -q : q;
        want.status = sat_flag ? STATUS_SAT : (zero_den_flag ? STATUS_ZERO_DEN : STATUS_OK);
      end
      want.count = count_q;
      expected_means.push_back(want);
      clear_frame();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_mean(logic [OUT_DATA_W-1:0] tdata);
      chi_result_t want;
      if (expected_means.size() == 0) begin
        report("unexpected result", tdata[SUM_W-1:0], '0);
        return;
      end
      want = expected_means.pop_front();
      if (tdata[SUM_W-1:0] !== want.mean)
        report("chi_mean", tdata[SUM_W-1:0], want.mean);
      if (tdata[SUM_W +: CNT_W] !== want.count)
        report("counted_pixels", tdata[SUM_W +: CNT_W], want.count);
      if (tdata[SUM_W+CNT_W +: STATUS_W] !== want.status)
        report("status", tdata[SUM_W+CNT_W +: STATUS_W], want.status);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [DATA_W-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  chi_mean_board board = new();
  int unsigned   tx_idle_pct = 22;
  int unsigned   rx_idle_pct = 50;
  bit            rx_hold_req = 1'b0;
  int unsigned   quiet_cycles = 0;

  masked_chi_square_accumulator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes are sampled before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) board.check_mean(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        board.take_pixel(s_axis_tdata[DATA_W-1:0], s_axis_tdata[IN_DATA_W-1:DATA_W],
                         s_axis_tuser, s_axis_tlast);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("masked_chi_square_accumulator_top test failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_pixel(input logic [DATA_W-1:0] data_q, input logic [DATA_W-1:0] model_q,
                            input logic sel, input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {model_q, data_q};
    s_axis_tuser  <= sel;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering pixels until every pending frame mean has come back
  task automatic wait_means_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_means.size() != 0) @(posedge clk_i);
  endtask

  // all four registers in index order, only while the block is idle
  task automatic set_registers(input logic [DATA_W-1:0] offset_v, input logic [DATA_W-1:0] noise_v,
                               input logic [DATA_W-1:0] gain_v, input logic mask_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [DATA_W-1:0]    val [4];
    idx[0] = REG_OFFSET_LEVEL;
    idx[1] = REG_NOISE_FLOOR;
    idx[2] = REG_NORM_GAIN;
    idx[3] = REG_MASK_ENABLE;
    val[0] = offset_v;
    val[1] = noise_v;
    val[2] = gain_v;
    val[3] = ($urandom() & ~32'd1) | 32'(mask_v);  // upper bits are don't-care
    wait_means_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // q16.16 values: full range, within plus or minus 16, or the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return $urandom();
    if (roll < 80) return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return GAIN_RESET;
      1:       return 32'h0000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_frame(input int unsigned len);
    logic [DATA_W-1:0] data_q, model_q;
    int unsigned       roll;
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      // data cancelling the noise floor gives zero or tiny denominators
      if (roll < 8) data_q = -board.noise_reg;
      else if (roll < 14) data_q = -board.noise_reg + ($urandom_range(6) - 3);
      else data_q = pick_value();
      // a fitted model mostly sits close to the data
      if ($urandom_range(1)) model_q = data_q + ($urandom_range(32'h0004_0000) - 32'h0002_0000);
      else model_q = pick_value();
      send_pixel(data_q, model_q, 1'($urandom_range(1)), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned sent, len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: unity gain, no mask
    send_pixel(32'h0001_0000, 32'h0000_0000, 1'b0, 1'b1);  // exact unity term
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);  // largest residual, not yet clipped
    send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);  // negative denominator
    send_pixel(32'h0000_0000, 32'h0000_0005, 1'b0, 1'b1);  // zero denominator
    send_pixel(32'h0000_0000, 32'h0001_2345, 1'b1, 1'b1);  // zero denominator only
    send_pixel(32'hFFFF_0000, 32'h0001_0000, 1'b1, 1'b1);  // negative mean

    // extremes: mask on, full gain
    set_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);  // nothing counted
    send_pixel(32'h8000_0002, 32'h8000_0000, 1'b1, 1'b0);  // term too large, den of one lsb
    send_pixel(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_pixel(32'h8000_0002, 32'h8000_0000, 1'b1, 1'b0);  // sum overflows high
    send_pixel(32'h8000_0002, 32'h8000_0000, 1'b1, 1'b1);
    send_pixel(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);  // den of minus one lsb
    send_pixel(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);  // sum overflows low

    // other extremes: zero gain, mask off
    set_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_pixel(32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       set_registers(32'h0000_0000, 32'h0000_0000, GAIN_RESET, 1'b0);
        1:       set_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        2:       set_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        default: set_registers(pick_value(), pick_value(), pick_gain(), 1'($urandom_range(1)));
      endcase
      // receiver idles more first, then the sender, then neither
      tx_idle_pct = (ph < 3) ? 22 : ((ph < 6) ? 50 : 0);
      rx_idle_pct = (ph < 3) ? 50 : ((ph < 6) ? 22 : 0);
      // long receiver hold-off with one-pixel frames to back the block up
      if (ph == 4) rx_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 4 && sent < 40) len = 1;
        else if ($urandom_range(9) == 0) len = $urandom_range(40, 11);
        else len = $urandom_range(10, 1);
        send_frame(len);
        sent += len;
        if ($urandom_range(19) == 0) wait_means_drained();
      end
    end

    wait_means_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("masked_chi_square_accumulator_top test passed");
    end else begin
      $display("masked_chi_square_accumulator_top test failed");
    end
    $finish;
  end

endmodule
